// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// File: design/eaam_pkg.sv
// Shared types, widths and constants of the Euler angle to affine matrix block.
package eaam_pkg;

    localparam int ANGLE_FIELD_W = 16;
    localparam int ORIGIN_W      = 32;
    localparam int COEF_FIELD_W  = 16;
    localparam int S_TDATA_W     = 144;
    localparam int M_TDATA_W     = 240;

    localparam int SC_STAGES     = 16;
    localparam int MX_STAGES     = 5;
    localparam int HORNER_STEPS  = 5;

    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [60:0] Q30_HALF    = 61'h2000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    localparam logic [30:0] SIN_RECIP [0:4] = '{
        31'd1249445032, 31'd1908874354, 31'd1636178018, 31'd1717986919, 31'd1431655766
    };
    localparam int SIN_SHIFT [0:4] = '{37, 37, 36, 35, 33};

    localparam logic [30:0] COS_RECIP [0:4] = '{
        31'd2082408386, 31'd1527099484, 31'd1227133514, 31'd1145324613, 31'd1431655766
    };
    localparam int COS_SHIFT [0:4] = '{38, 37, 36, 35, 34};

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;

    typedef struct packed {
        logic [1:0]  quad;
        logic        swap;
        logic [29:0] rad;
    } side_t;

    typedef struct packed {
        logic signed [ORIGIN_W-1:0] x;
        logic signed [ORIGIN_W-1:0] y;
        logic signed [ORIGIN_W-1:0] z;
    } origin_t;

    function automatic logic [30:0] q30_round(input logic [60:0] p);
        logic [60:0] sum;
        sum = p + Q30_HALF;
        return sum[60:30];
    endfunction

endpackage

// File: design/eaam_sincos.sv
// Pipelined sine and cosine of one binary angle by Taylor series in Q30.
module eaam_sincos #(
    parameter int ANGLE_BITS     = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                               aclk,
    input  logic [eaam_pkg::SC_STAGES-1:0]     stage_en,
    input  logic [ANGLE_BITS-1:0]              angle,
    output logic signed [COEF_FRAC_BITS+1:0]   sin_val,
    output logic signed [COEF_FRAC_BITS+1:0]   cos_val
);

    localparam int FB = ANGLE_BITS - 2;
    localparam int PW = FB + 31;
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int SH = 30 - COEF_FRAC_BITS;
    localparam logic [FB-1:0] EIGHTH    = FB'(1) << (FB - 1);
    localparam logic [PW:0]   RAD_RND   = (PW + 1)'(EIGHTH);
    localparam logic [31:0]   COEF_RND  = (32'd1 << SH) >> 1;
    localparam int LAST = eaam_pkg::SC_STAGES - 1;

    function automatic logic [COEF_FRAC_BITS:0] to_coef(input logic [30:0] v);
        logic [31:0] sum;
        sum = 32'(v) + COEF_RND;
        return sum[SH +: COEF_FRAC_BITS + 1];
    endfunction

    eaam_pkg::side_t side_reg [0:LAST-1];

    logic [1:0]    quad;
    logic [FB-1:0] frac;
    logic [FB-1:0] fold;
    logic          swap;
    logic [PW-1:0] rad_prod_reg;
    logic [PW:0]   rad_sum;
    logic [59:0]   rr_reg;
    logic [29:0]   r2_reg;
    logic [30:0]   t_s [0:eaam_pkg::HORNER_STEPS];
    logic [30:0]   t_c [0:eaam_pkg::HORNER_STEPS];
    logic [29:0]   r2_b [0:eaam_pkg::HORNER_STEPS];
    logic [60:0]   fs_reg;
    logic [60:0]   fc_reg;

    always_comb begin
        quad = angle[ANGLE_BITS-1 -: 2];
        frac = angle[FB-1:0];
        swap = frac > EIGHTH;
        fold = swap ? (FB'(0) - frac) : frac;
        rad_sum = (PW + 1)'(rad_prod_reg) + RAD_RND;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            rad_prod_reg <= PW'(fold) * PW'(eaam_pkg::HALF_PI_Q30);
            side_reg[0]  <= '{quad: quad, swap: swap, rad: 30'd0};
        end
        if (stage_en[1]) begin
            side_reg[1] <= '{quad: side_reg[0].quad, swap: side_reg[0].swap,
                             rad: rad_sum[FB +: 30]};
        end
        if (stage_en[2]) begin
            rr_reg <= 60'(side_reg[1].rad) * 60'(side_reg[1].rad);
        end
        if (stage_en[3]) begin
            r2_reg <= 30'(eaam_pkg::q30_round(61'(rr_reg)));
        end
    end

    genvar gi;
    generate
        for (gi = 2; gi < LAST; gi++) begin : g_side
            always_ff @(posedge aclk) begin
                if (stage_en[gi]) begin
                    side_reg[gi] <= side_reg[gi-1];
                end
            end
        end

        assign t_s[0]  = eaam_pkg::Q30_ONE;
        assign t_c[0]  = eaam_pkg::Q30_ONE;
        assign r2_b[0] = r2_reg;

        for (gi = 0; gi < eaam_pkg::HORNER_STEPS; gi++) begin : g_step
            logic [60:0] ps_reg;
            logic [60:0] pc_reg;
            logic [29:0] r2a_reg;
            logic [60:0] qs_reg;
            logic [60:0] qc_reg;
            logic [29:0] r2b_reg;

            always_ff @(posedge aclk) begin
                if (stage_en[4 + 2*gi]) begin
                    ps_reg  <= 61'(r2_b[gi]) * 61'(t_s[gi]);
                    pc_reg  <= 61'(r2_b[gi]) * 61'(t_c[gi]);
                    r2a_reg <= r2_b[gi];
                end
                if (stage_en[5 + 2*gi]) begin
                    qs_reg  <= 61'(30'(eaam_pkg::q30_round(ps_reg)))
                               * 61'(eaam_pkg::SIN_RECIP[gi]);
                    qc_reg  <= 61'(30'(eaam_pkg::q30_round(pc_reg)))
                               * 61'(eaam_pkg::COS_RECIP[gi]);
                    r2b_reg <= r2a_reg;
                end
            end

            assign t_s[gi+1]  = eaam_pkg::Q30_ONE - 31'(qs_reg >> eaam_pkg::SIN_SHIFT[gi]);
            assign t_c[gi+1]  = eaam_pkg::Q30_ONE - 31'(qc_reg >> eaam_pkg::COS_SHIFT[gi]);
            assign r2_b[gi+1] = r2b_reg;
        end
    endgenerate

    logic [30:0]           sin_q30;
    logic [30:0]           cos_q30;
    logic [COEF_FRAC_BITS:0] sv;
    logic [COEF_FRAC_BITS:0] cv;
    logic signed [CW-1:0]  s0;
    logic signed [CW-1:0]  c0;
    logic signed [CW-1:0]  sin_next;
    logic signed [CW-1:0]  cos_next;
    logic signed [CW-1:0]  sin_reg;
    logic signed [CW-1:0]  cos_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[LAST-1]) begin
            fs_reg <= 61'(side_reg[LAST-2].rad) * 61'(t_s[eaam_pkg::HORNER_STEPS]);
            fc_reg <= 61'(r2_b[eaam_pkg::HORNER_STEPS]) * 61'(t_c[eaam_pkg::HORNER_STEPS]);
        end
    end

    always_comb begin
        sin_q30 = eaam_pkg::q30_round(fs_reg);
        cos_q30 = eaam_pkg::Q30_ONE - (eaam_pkg::q30_round(fc_reg) >> 1);
        sv = to_coef(sin_q30);
        cv = to_coef(cos_q30);
        s0 = side_reg[LAST-1].swap ? $signed({1'b0, cv}) : $signed({1'b0, sv});
        c0 = side_reg[LAST-1].swap ? $signed({1'b0, sv}) : $signed({1'b0, cv});
        case (side_reg[LAST-1].quad)
            eaam_pkg::QUAD_FIRST: begin
                sin_next = s0;
                cos_next = c0;
            end
            eaam_pkg::QUAD_SECOND: begin
                sin_next = c0;
                cos_next = -s0;
            end
            eaam_pkg::QUAD_THIRD: begin
                sin_next = -s0;
                cos_next = -c0;
            end
            default: begin
                sin_next = -c0;
                cos_next = s0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_en[LAST]) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

// File: design/eaam_matrix.sv
// Pipelined rotation term products, rounding, sums and saturation.
module eaam_matrix #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                                   aclk,
    input  logic [eaam_pkg::MX_STAGES-1:0]         stage_en,
    input  logic signed [COEF_FRAC_BITS+1:0]       sp,
    input  logic signed [COEF_FRAC_BITS+1:0]       cp,
    input  logic signed [COEF_FRAC_BITS+1:0]       sy,
    input  logic signed [COEF_FRAC_BITS+1:0]       cy,
    input  logic signed [COEF_FRAC_BITS+1:0]       sr,
    input  logic signed [COEF_FRAC_BITS+1:0]       cr,
    output logic [eaam_pkg::COEF_FIELD_W-1:0]      row0_col0,
    output logic [eaam_pkg::COEF_FIELD_W-1:0]      row0_col1,
    output logic [eaam_pkg::COEF_FIELD_W-1:0]      row0_col2,
    output logic [eaam_pkg::COEF_FIELD_W-1:0]      row1_col0,
    output logic [eaam_pkg::COEF_FIELD_W-1:0]      row1_col1,
    output logic [eaam_pkg::COEF_FIELD_W-1:0]      row1_col2,
    output logic [eaam_pkg::COEF_FIELD_W-1:0]      row2_col0,
    output logic [eaam_pkg::COEF_FIELD_W-1:0]      row2_col1,
    output logic [eaam_pkg::COEF_FIELD_W-1:0]      row2_col2
);

    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int PW = 2 * CW;
    localparam int EW = (CW + 1 > eaam_pkg::COEF_FIELD_W) ? CW + 1 : eaam_pkg::COEF_FIELD_W;
    localparam logic [PW-1:0]    PROD_RND = PW'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [CW:0] COEF_ONE = (CW + 1)'(1) << COEF_FRAC_BITS;
    localparam logic signed [CW:0] COEF_NEG_ONE = -COEF_ONE;

    function automatic logic signed [CW-1:0] cround(input logic signed [PW-1:0] p);
        logic [PW-1:0]        mag;
        logic [PW-1:0]        sum;
        logic signed [CW-1:0] m;
        mag = p[PW-1] ? (~p + PW'(1)) : p;
        sum = mag + PROD_RND;
        m = $signed(sum[COEF_FRAC_BITS +: CW]);
        return p[PW-1] ? -m : m;
    endfunction

    function automatic logic [eaam_pkg::COEF_FIELD_W-1:0] coef_out(
        input logic signed [CW:0] v
    );
        logic signed [CW:0]   c;
        logic signed [EW-1:0] e;
        c = (v > COEF_ONE) ? COEF_ONE : ((v < COEF_NEG_ONE) ? COEF_NEG_ONE : v);
        e = EW'(c);
        return e[eaam_pkg::COEF_FIELD_W-1:0];
    endfunction

    logic signed [PW-1:0] p_srsp_reg, p_crsp_reg, p_cpcy_reg, p_crsy_reg, p_srsy_reg;
    logic signed [PW-1:0] p_cpsy_reg, p_crcy_reg, p_srcy_reg, p_srcp_reg, p_crcp_reg;
    logic signed [CW-1:0] nsp0_reg, cy0_reg, sy0_reg;

    logic signed [CW-1:0] srsp_reg, crsp_reg, cpcy_reg, crsy_reg, srsy_reg;
    logic signed [CW-1:0] cpsy_reg, crcy_reg, srcy_reg, srcp_reg, crcp_reg;
    logic signed [CW-1:0] nsp1_reg, cy1_reg, sy1_reg;

    logic signed [PW-1:0] p_srspcy_reg, p_srspsy_reg, p_crspcy_reg, p_crspsy_reg;
    logic signed [CW-1:0] cpcy2_reg, crsy2_reg, srsy2_reg, cpsy2_reg, crcy2_reg;
    logic signed [CW-1:0] srcy2_reg, srcp2_reg, crcp2_reg, nsp2_reg;

    logic signed [CW-1:0] srspcy_reg, srspsy_reg, crspcy_reg, crspsy_reg;
    logic signed [CW-1:0] cpcy3_reg, crsy3_reg, srsy3_reg, cpsy3_reg, crcy3_reg;
    logic signed [CW-1:0] srcy3_reg, srcp3_reg, crcp3_reg, nsp3_reg;

    logic [eaam_pkg::COEF_FIELD_W-1:0] c00_reg, c01_reg, c02_reg, c10_reg, c11_reg;
    logic [eaam_pkg::COEF_FIELD_W-1:0] c12_reg, c20_reg, c21_reg, c22_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            p_srsp_reg <= PW'(sr) * PW'(sp);
            p_crsp_reg <= PW'(cr) * PW'(sp);
            p_cpcy_reg <= PW'(cp) * PW'(cy);
            p_crsy_reg <= PW'(cr) * PW'(sy);
            p_srsy_reg <= PW'(sr) * PW'(sy);
            p_cpsy_reg <= PW'(cp) * PW'(sy);
            p_crcy_reg <= PW'(cr) * PW'(cy);
            p_srcy_reg <= PW'(sr) * PW'(cy);
            p_srcp_reg <= PW'(sr) * PW'(cp);
            p_crcp_reg <= PW'(cr) * PW'(cp);
            nsp0_reg   <= -sp;
            cy0_reg    <= cy;
            sy0_reg    <= sy;
        end
        if (stage_en[1]) begin
            srsp_reg <= cround(p_srsp_reg);
            crsp_reg <= cround(p_crsp_reg);
            cpcy_reg <= cround(p_cpcy_reg);
            crsy_reg <= cround(p_crsy_reg);
            srsy_reg <= cround(p_srsy_reg);
            cpsy_reg <= cround(p_cpsy_reg);
            crcy_reg <= cround(p_crcy_reg);
            srcy_reg <= cround(p_srcy_reg);
            srcp_reg <= cround(p_srcp_reg);
            crcp_reg <= cround(p_crcp_reg);
            nsp1_reg <= nsp0_reg;
            cy1_reg  <= cy0_reg;
            sy1_reg  <= sy0_reg;
        end
        if (stage_en[2]) begin
            p_srspcy_reg <= PW'(srsp_reg) * PW'(cy1_reg);
            p_srspsy_reg <= PW'(srsp_reg) * PW'(sy1_reg);
            p_crspcy_reg <= PW'(crsp_reg) * PW'(cy1_reg);
            p_crspsy_reg <= PW'(crsp_reg) * PW'(sy1_reg);
            cpcy2_reg <= cpcy_reg;
            crsy2_reg <= crsy_reg;
            srsy2_reg <= srsy_reg;
            cpsy2_reg <= cpsy_reg;
            crcy2_reg <= crcy_reg;
            srcy2_reg <= srcy_reg;
            srcp2_reg <= srcp_reg;
            crcp2_reg <= crcp_reg;
            nsp2_reg  <= nsp1_reg;
        end
        if (stage_en[3]) begin
            srspcy_reg <= cround(p_srspcy_reg);
            srspsy_reg <= cround(p_srspsy_reg);
            crspcy_reg <= cround(p_crspcy_reg);
            crspsy_reg <= cround(p_crspsy_reg);
            cpcy3_reg <= cpcy2_reg;
            crsy3_reg <= crsy2_reg;
            srsy3_reg <= srsy2_reg;
            cpsy3_reg <= cpsy2_reg;
            crcy3_reg <= crcy2_reg;
            srcy3_reg <= srcy2_reg;
            srcp3_reg <= srcp2_reg;
            crcp3_reg <= crcp2_reg;
            nsp3_reg  <= nsp2_reg;
        end
        if (stage_en[4]) begin
            c00_reg <= coef_out((CW + 1)'(cpcy3_reg));
            c01_reg <= coef_out((CW + 1)'(srspcy_reg) - (CW + 1)'(crsy3_reg));
            c02_reg <= coef_out((CW + 1)'(crspcy_reg) + (CW + 1)'(srsy3_reg));
            c10_reg <= coef_out((CW + 1)'(cpsy3_reg));
            c11_reg <= coef_out((CW + 1)'(srspsy_reg) + (CW + 1)'(crcy3_reg));
            c12_reg <= coef_out((CW + 1)'(crspsy_reg) - (CW + 1)'(srcy3_reg));
            c20_reg <= coef_out((CW + 1)'(nsp3_reg));
            c21_reg <= coef_out((CW + 1)'(srcp3_reg));
            c22_reg <= coef_out((CW + 1)'(crcp3_reg));
        end
    end

    assign row0_col0 = c00_reg;
    assign row0_col1 = c01_reg;
    assign row0_col2 = c02_reg;
    assign row1_col0 = c10_reg;
    assign row1_col1 = c11_reg;
    assign row1_col2 = c12_reg;
    assign row2_col0 = c20_reg;
    assign row2_col1 = c21_reg;
    assign row2_col2 = c22_reg;

endmodule

// File: design/euler_angles_to_affine_matrix_top.sv
// Top level: Euler angles and origin in, 3x4 affine matrix out.
// Takes one request per cycle while the output is not stalled and returns
// its matrix in order. The pipeline runs through the sine and cosine
// series: five Horner steps of two registered multiplies each, plus angle
// folding and the radian scale, then five stages of coefficient products,
// rounding and sums. Each stage holds its own valid bit, so a stall at the
// output fills empty stages before the input is held off.
module euler_angles_to_affine_matrix_top #(
    parameter int ANGLE_BITS     = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pitch_angle, yaw_angle, roll_angle, origin_x, origin_y, origin_z
    input  logic [eaam_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // row0_col0, row0_col1, row0_col2, row0_trans, row1_col0, row1_col1,
    // row1_col2, row1_trans, row2_col0, row2_col1, row2_col2, row2_trans
    output logic [eaam_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int NST = eaam_pkg::SC_STAGES + eaam_pkg::MX_STAGES;
    localparam int CW  = COEF_FRAC_BITS + 2;

    logic [NST-1:0]    stage_en;
    logic [NST-1:0]    vld_reg;
    logic [NST-1:0]    vld_next;
    eaam_pkg::origin_t orig_reg [0:NST-1];

    logic signed [CW-1:0] sp, cp, sy, cy, sr, cr;
    logic [eaam_pkg::COEF_FIELD_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

    assign stage_en[NST-1] = !vld_reg[NST-1] || m_tready;
    assign vld_next[0]     = stage_en[0] ? s_tvalid : vld_reg[0];

    genvar gi;
    generate
        for (gi = 0; gi < NST - 1; gi++) begin : g_ctrl
            assign stage_en[gi]   = !vld_reg[gi] || stage_en[gi+1];
            assign vld_next[gi+1] = stage_en[gi+1] ? vld_reg[gi] : vld_reg[gi+1];
            always_ff @(posedge aclk) begin
                if (stage_en[gi+1]) begin
                    orig_reg[gi+1] <= orig_reg[gi];
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            orig_reg[0] <= '{x: s_tdata[79:48], y: s_tdata[111:80], z: s_tdata[143:112]};
        end
    end

    eaam_sincos #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_pitch (
        .aclk     (aclk),
        .stage_en (stage_en[eaam_pkg::SC_STAGES-1:0]),
        .angle    (ANGLE_BITS'(s_tdata[15:0])),
        .sin_val  (sp),
        .cos_val  (cp)
    );

    eaam_sincos #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_yaw (
        .aclk     (aclk),
        .stage_en (stage_en[eaam_pkg::SC_STAGES-1:0]),
        .angle    (ANGLE_BITS'(s_tdata[31:16])),
        .sin_val  (sy),
        .cos_val  (cy)
    );

    eaam_sincos #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_roll (
        .aclk     (aclk),
        .stage_en (stage_en[eaam_pkg::SC_STAGES-1:0]),
        .angle    (ANGLE_BITS'(s_tdata[47:32])),
        .sin_val  (sr),
        .cos_val  (cr)
    );

    eaam_matrix #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_matrix (
        .aclk      (aclk),
        .stage_en  (stage_en[NST-1:eaam_pkg::SC_STAGES]),
        .sp        (sp),
        .cp        (cp),
        .sy        (sy),
        .cy        (cy),
        .sr        (sr),
        .cr        (cr),
        .row0_col0 (r00),
        .row0_col1 (r01),
        .row0_col2 (r02),
        .row1_col0 (r10),
        .row1_col1 (r11),
        .row1_col2 (r12),
        .row2_col0 (r20),
        .row2_col1 (r21),
        .row2_col2 (r22)
    );

    assign s_tready = stage_en[0];
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = {orig_reg[NST-1].z, r22, r21, r20,
                       orig_reg[NST-1].y, r12, r11, r10,
                       orig_reg[NST-1].x, r02, r01, r00};

endmodule

// File: design/eaam_checker.sv
// Port-level checker for the Euler angle to affine matrix block, with its bind.
`include "assert_macros.svh"

module eaam_checker #(
    parameter int COEF_FRAC_BITS = 14
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [eaam_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam logic signed [17:0] LIM = (COEF_FRAC_BITS > 14) ? 18'sd0 : 18'sd16384;
    localparam logic               WIDE = COEF_FRAC_BITS > 14;

    logic signed [17:0] c01;
    logic signed [17:0] c20;

    assign c01 = 18'($signed(m_tdata[31:16]));
    assign c20 = 18'($signed(m_tdata[175:160]));

    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid)
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `ASSERT_CLK(a_ready_when_empty, aclk, aresetn, !m_tvalid |-> s_tready)
    `ASSERT_CLK(a_coef_range, aclk, aresetn, m_tvalid |-> WIDE || ((c01 <= LIM) && (c01 >= -LIM) && (c20 <= LIM) && (c20 >= -LIM)))

endmodule

bind euler_angles_to_affine_matrix_top eaam_checker #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
) u_eaam_checker (.*);

// File: sim/euler_angles_to_affine_matrix_top_tb.sv
// Self-checking testbench for the Euler angle to affine matrix block.
module euler_angles_to_affine_matrix_top_tb;

    localparam int ABITS = 16;
    localparam int FBITS = 14;
    localparam int RANDOM_ITEMS = 750;
    localparam logic [63:0] Q1 = 64'd1 << 30;
    localparam logic [63:0] QH = 64'd1 << 29;
    localparam logic [63:0] HPI = 64'd1686629713;
    localparam logic [15:0] ONE = 16'sd16384;
    localparam logic [15:0] NEG_ONE = -16'sd16384;

    typedef struct {
        logic [15:0] ang [3];
        logic [31:0] org [3];
        logic        known;
        logic [15:0] rot [9];
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [eaam_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [eaam_pkg::M_TDATA_W-1:0] m_tdata;

    logic [eaam_pkg::M_TDATA_W-1:0] matrix_q [$];
    int mismatches = 0;
    int matrices_seen = 0;
    int requests_sent = 0;
    logic stall_free = 1'b0;
    stim_row_t rows [$];

    euler_angles_to_affine_matrix_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        return (a * b + QH) >> 30;
    endfunction

    function automatic logic [63:0] series(logic [63:0] r, bit is_cos);
        logic [63:0] r2, t;
        int divs [5];
        r2 = qmul(r, r);
        if (is_cos) divs = '{132, 90, 56, 30, 12};
        else divs = '{110, 72, 42, 20, 6};
        t = Q1;
        for (int i = 0; i < 5; i++) t = Q1 - qmul(r2, t) / divs[i];
        if (is_cos) return Q1 - qmul(r2, t) / 2;
        return qmul(r, t);
    endfunction

    function automatic longint to_q14(logic [63:0] v);
        return longint'((v + (64'd1 << (29 - FBITS))) >> (30 - FBITS));
    endfunction

    task automatic sincos(input logic [15:0] a, output longint s, output longint c);
        longint sv, cv, s0, c0;
        logic [63:0] f, g, r;
        f = a & 16'h3FFF;
        g = (f > 64'h2000) ? 64'h4000 - f : f;
        r = (g * HPI + 64'h2000) >> (ABITS - 2);
        sv = to_q14(series(r, 1'b0));
        cv = to_q14(series(r, 1'b1));
        s0 = (f > 64'h2000) ? cv : sv;
        c0 = (f > 64'h2000) ? sv : cv;
        case (a[15:14])
            2'd0: begin s = s0; c = c0; end
            2'd1: begin s = c0; c = -s0; end
            2'd2: begin s = -s0; c = -c0; end
            default: begin s = -c0; c = s0; end
        endcase
    endtask

    function automatic longint cmul(longint a, longint b);
        longint p, m;
        p = a * b;
        m = ((p < 0 ? -p : p) + (64'sd1 <<< (FBITS - 1))) >>> FBITS;
        return p < 0 ? -m : m;
    endfunction

    function automatic logic [15:0] clamp_coef(longint v);
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        return v[15:0];
    endfunction

    function automatic logic [eaam_pkg::M_TDATA_W-1:0] pack_matrix(logic [15:0] rot [9],
                                                                   logic [31:0] org [3]);
        logic [eaam_pkg::M_TDATA_W-1:0] m;
        m = {org[2], rot[8], rot[7], rot[6], org[1], rot[5], rot[4], rot[3],
             org[0], rot[2], rot[1], rot[0]};
        return m;
    endfunction

    task automatic predict_matrix(input logic [15:0] ang [3], input logic [31:0] org [3],
                                  output logic [eaam_pkg::M_TDATA_W-1:0] m);
        longint sp, cp, sy, cy, sr, cr, srsp, crsp;
        logic [15:0] rot [9];
        sincos(ang[0], sp, cp);
        sincos(ang[1], sy, cy);
        sincos(ang[2], sr, cr);
        srsp = cmul(sr, sp);
        crsp = cmul(cr, sp);
        rot[0] = clamp_coef(cmul(cp, cy));
        rot[1] = clamp_coef(cmul(srsp, cy) - cmul(cr, sy));
        rot[2] = clamp_coef(cmul(crsp, cy) + cmul(sr, sy));
        rot[3] = clamp_coef(cmul(cp, sy));
        rot[4] = clamp_coef(cmul(srsp, sy) + cmul(cr, cy));
        rot[5] = clamp_coef(cmul(crsp, sy) - cmul(sr, cy));
        rot[6] = clamp_coef(-sp);
        rot[7] = clamp_coef(cmul(sr, cp));
        rot[8] = clamp_coef(cmul(cr, cp));
        m = pack_matrix(rot, org);
    endtask

    function automatic stim_row_t make_row(logic [15:0] p, logic [15:0] y, logic [15:0] r,
                                           logic [31:0] ox, logic [31:0] oy,
                                           logic [31:0] oz);
        stim_row_t t;
        t.ang = '{p, y, r};
        t.org = '{ox, oy, oz};
        t.known = 1'b0;
        t.rot = '{default: '0};
        return t;
    endfunction

    task automatic send_request(input stim_row_t t);
        logic [eaam_pkg::M_TDATA_W-1:0] m;
        predict_matrix(t.ang, t.org, m);
        if (t.known && m != pack_matrix(t.rot, t.org)) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees with prediction: %h vs %h",
                         pack_matrix(t.rot, t.org), m);
        end
        while (!stall_free && $urandom_range(0, 99) < 6) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {t.org[2], t.org[1], t.org[0], t.ang[2], t.ang[1], t.ang[0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        matrix_q.push_back(t.known ? pack_matrix(t.rot, t.org) : m);
        requests_sent++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            matrices_seen++;
            if (matrix_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected matrix %h", m_tdata);
            end else begin
                logic [eaam_pkg::M_TDATA_W-1:0] want;
                want = matrix_q.pop_front();
                if (want != m_tdata) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("matrix mismatch: expected %h got %h", want, m_tdata);
                end
            end
        end
        if (aresetn) m_tready <= stall_free || ($urandom_range(0, 99) >= 6);
    end

    initial begin
        #5_000_000;
        $display("euler_angles_to_affine_matrix_top_tb failed");
        $finish;
    end

    initial begin
        stim_row_t t;
        logic [31:0] o [3];
        // zero angles: identity rotation
        t = make_row(16'h0000, 16'h0000, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        t.known = 1'b1;
        t.rot = '{ONE, 16'h0, 16'h0, 16'h0, ONE, 16'h0, 16'h0, 16'h0, ONE};
        rows.push_back(t);
        // half turn of pitch
        t = make_row(16'h8000, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 32'h1, 32'h0001_0000);
        t.known = 1'b1;
        t.rot = '{NEG_ONE, 16'h0, 16'h0, 16'h0, ONE, 16'h0, 16'h0, 16'h0, NEG_ONE};
        rows.push_back(t);
        rows.push_back(make_row(16'h4000, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0));
        rows.push_back(make_row(16'hC000, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0));
        rows.push_back(make_row(16'h0000, 16'h4000, 16'h0000, 32'h0, 32'h0, 32'h0));
        rows.push_back(make_row(16'h0000, 16'h0000, 16'h4000, 32'h0, 32'h0, 32'h0));
        rows.push_back(make_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF));
        rows.push_back(make_row(16'h2000, 16'h2000, 16'h2000, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h8000_0000));
        rows.push_back(make_row(16'h2001, 16'h1FFF, 16'h6000, 32'h1, 32'h2, 32'h3));
        rows.push_back(make_row(16'h0001, 16'h3FFF, 16'h4001, 32'h0, 32'h0, 32'h0));
        rows.push_back(make_row(16'hA000, 16'hE000, 16'h0000, 32'h5555_5555,
                                32'hAAAA_AAAA, 32'h5555_5555));
        rows.push_back(make_row(16'h1234, 16'h0000, 16'h9876, 32'h0, 32'h0, 32'h0));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (rows[i]) send_request(rows[i]);
        s_tvalid <= 1'b0;
        while (matrix_q.size() != 0) @(posedge aclk);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            stall_free <= (n >= 300 && n < 400);
            for (int k = 0; k < 3; k++) o[k] = $urandom;
            t = make_row(16'($urandom), 16'($urandom), 16'($urandom), o[0], o[1], o[2]);
            if ($urandom_range(0, 9) == 0) t.ang[$urandom_range(0, 2)] = 16'h0;
            if ($urandom_range(0, 9) == 0) t.ang[$urandom_range(0, 2)] =
                16'($urandom_range(0, 3)) << 14;
            send_request(t);
        end
        s_tvalid <= 1'b0;
        stall_free <= 1'b0;
        while (matrix_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("sent %0d angle sets, checked %0d matrices, %0d mismatches",
                 requests_sent, matrices_seen, mismatches);
        $display("covered quarter turns, zero angles, wrap extremes and random origins");
        if (mismatches == 0)
            $display("euler_angles_to_affine_matrix_top_tb passed");
        else
            $display("euler_angles_to_affine_matrix_top_tb failed");
        $finish;
    end
endmodule
